// ----- rtl/udprhb_pkg.sv -----
// ============================================================================
// udprhb_pkg: shared types and constants of the UDP/IPv4 reply header builder
// Payload structs for both channels, stage records and a checksum fold helper.
// ============================================================================
`default_nettype none

package udprhb_pkg;

  // Widest register on the configuration port
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_IP_TOS  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_IP_TTL  = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_IP_FRAG = 2'd2;

  // Register reset values
  localparam logic [7:0]  TosReset  = 8'h00;
  localparam logic [7:0]  TtlReset  = 8'd64;
  localparam logic [15:0] FragReset = 16'h4000;

  // Byte counter width, enough for the largest jumbo payload (8972)
  localparam int unsigned CountW = 14;
  // Raw checksum sums: at most ten 16-bit terms
  localparam int unsigned SumW   = 20;
  localparam int unsigned AddrW  = 18;

  localparam logic [15:0] IdentReset  = 16'h012a;
  localparam logic [7:0]  ProtoUdp    = 8'd17;
  localparam logic [7:0]  VerIhl      = 8'h45;
  localparam logic [15:0] IpUdpHdrLen = 16'd28;
  localparam logic [15:0] UdpHdrLen   = 16'd8;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        has_byte;
    logic        last;
    logic [31:0] local_ip;
    logic [31:0] remote_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
  } in_item_t;

  typedef struct packed {
    logic [10:0] ip_total_length;
    logic [15:0] ip_ident;
    logic [15:0] ip_header_sum;
    logic [10:0] udp_length;
    logic [15:0] udp_sum;
    logic        too_long;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  ip_tos;
    logic [7:0]  ip_ttl;
    logic [15:0] ip_frag_word;
  } cfg_t;

  // Packet record handed from the accumulator to the sum stage
  typedef struct packed {
    logic [15:0]       payload_sum;
    logic [CountW-1:0] byte_count;
    logic              too_long;
    logic [15:0]       ident;
    logic [AddrW-1:0]  addr_sum;
    logic [15:0]       src_port;
    logic [15:0]       dst_port;
  } fin_t;

  // Unfolded checksum sums handed to the output stage
  typedef struct packed {
    logic [SumW-1:0] ip_sum;
    logic [SumW-1:0] udp_sum;
    logic [10:0]     tot_len;
    logic [10:0]     udp_len;
    logic [15:0]     ident;
    logic            too_long;
  } sum_t;

  // Fold a 20-bit sum into 16 bits with end-around carries
  function automatic logic [15:0] fold20(input logic [SumW-1:0] s);
    logic [16:0] t;
    logic [16:0] r;
    t = {1'b0, s[15:0]} + {13'd0, s[19:16]};
    r = {1'b0, t[15:0]} + {16'd0, t[16]};
    return r[15:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/udprhb_accum.sv -----
// ============================================================================
// udprhb_accum: payload accumulator
// Pairs payload bytes into network-order words, keeps the running ones'
// complement sum, byte count, overflow flag and IP ident counter, and
// registers one packet record on the last item.
// ============================================================================
`default_nettype none

module udprhb_accum #(
  parameter int unsigned MAX_PAYLOAD = 1472
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    item_valid_i,
  input  udprhb_pkg::in_item_t   item_i,
  output logic                   item_ready_o,
  output logic                   fin_valid_o,
  output udprhb_pkg::fin_t       fin_o,
  input  wire                    fin_ready_i
);

  localparam logic [udprhb_pkg::CountW-1:0] MaxCount = udprhb_pkg::CountW'(MAX_PAYLOAD);

  // 16-bit ones' complement add
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] r;
    s = {1'b0, a} + {1'b0, b};
    r = {1'b0, s[15:0]} + {16'd0, s[16]};
    return r[15:0];
  endfunction

  logic [15:0]                   psum_q, psum_d;
  logic [udprhb_pkg::CountW-1:0] count_q, count_d;
  logic [7:0]                    held_q, held_d;
  logic                          odd_q, odd_d;
  logic                          ovf_q, ovf_d;
  logic [15:0]                   ident_q, ident_d;
  logic                          fin_valid_q;
  udprhb_pkg::fin_t              fin_q, fin_d;

  logic                          fin_free;
  logic                          fire;
  logic                          take;
  logic [15:0]                   word;
  logic [15:0]                   psum_new;
  logic [udprhb_pkg::CountW-1:0] count_new;
  logic                          ovf_new;
  logic [15:0]                   ident_new;
  logic [udprhb_pkg::AddrW-1:0]  addr_sum;

  // Handshake: only a last item needs room in the record register
  assign fin_free     = !fin_valid_q || fin_ready_i;
  assign item_ready_o = !item_i.last || fin_free;
  assign fire         = item_valid_i && item_ready_o;

  // Byte is summed only below the length limit
  assign take = item_i.has_byte && (count_q < MaxCount);

  // Select the single word that this item adds to the sum
  always_comb begin
    word = 16'd0;
    if (take && odd_q) begin
      word = {held_q, item_i.payload_byte};
    end else if (take && item_i.last) begin
      word = {item_i.payload_byte, 8'h00};
    end else if (!take && odd_q && item_i.last) begin
      word = {held_q, 8'h00};
    end
  end

  assign psum_new  = oc_add(psum_q, word);
  assign count_new = count_q + udprhb_pkg::CountW'(take);
  assign ovf_new   = ovf_q || (item_i.has_byte && !take);
  assign ident_new = ident_q + 16'd1;
  assign addr_sum  = udprhb_pkg::AddrW'(item_i.local_ip[31:16])
                   + udprhb_pkg::AddrW'(item_i.local_ip[15:0])
                   + udprhb_pkg::AddrW'(item_i.remote_ip[31:16])
                   + udprhb_pkg::AddrW'(item_i.remote_ip[15:0]);

  // Next packet state
  always_comb begin
    psum_d  = psum_q;
    count_d = count_q;
    held_d  = held_q;
    odd_d   = odd_q;
    ovf_d   = ovf_q;
    ident_d = ident_q;
    if (fire) begin
      if (item_i.last) begin
        psum_d  = 16'd0;
        count_d = '0;
        held_d  = 8'h00;
        odd_d   = 1'b0;
        ovf_d   = 1'b0;
        ident_d = ident_new;
      end else begin
        psum_d  = psum_new;
        count_d = count_new;
        ovf_d   = ovf_new;
        if (take) begin
          odd_d = !odd_q;
          if (!odd_q) begin
            held_d = item_i.payload_byte;
          end
        end
      end
    end
  end

  // Packet record
  always_comb begin
    fin_d.payload_sum = psum_new;
    fin_d.byte_count  = count_new;
    fin_d.too_long    = ovf_new;
    fin_d.ident       = ident_new;
    fin_d.addr_sum    = addr_sum;
    fin_d.src_port    = item_i.src_port;
    fin_d.dst_port    = item_i.dst_port;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psum_q      <= 16'd0;
      count_q     <= '0;
      held_q      <= 8'h00;
      odd_q       <= 1'b0;
      ovf_q       <= 1'b0;
      ident_q     <= udprhb_pkg::IdentReset;
      fin_valid_q <= 1'b0;
    end else begin
      psum_q  <= psum_d;
      count_q <= count_d;
      held_q  <= held_d;
      odd_q   <= odd_d;
      ovf_q   <= ovf_d;
      ident_q <= ident_d;
      if (fin_free) begin
        fin_valid_q <= fire && item_i.last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_free && fire && item_i.last) begin
      fin_q <= fin_d;
    end
  end

  assign fin_valid_o = fin_valid_q;
  assign fin_o       = fin_q;

endmodule

`default_nettype wire

// ----- rtl/udprhb_sum.sv -----
// ============================================================================
// udprhb_sum: header sum stage
// Builds the lengths and the unfolded IPv4 header and UDP checksum sums
// from one packet record and the configured header fields.
// ============================================================================
`default_nettype none

module udprhb_sum (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  udprhb_pkg::cfg_t   cfg_i,
  input  wire                fin_valid_i,
  input  udprhb_pkg::fin_t   fin_i,
  output logic               fin_ready_o,
  output logic               sum_valid_o,
  output udprhb_pkg::sum_t   sum_o,
  input  wire                sum_ready_i
);

  localparam int unsigned SW = udprhb_pkg::SumW;

  logic             sum_valid_q;
  udprhb_pkg::sum_t sum_q, sum_d;
  logic [15:0]      tot16;
  logic [15:0]      ulen16;

  assign fin_ready_o = !sum_valid_q || sum_ready_i;

  // Length words as they appear in the headers
  assign tot16  = 16'(fin_i.byte_count) + udprhb_pkg::IpUdpHdrLen;
  assign ulen16 = 16'(fin_i.byte_count) + udprhb_pkg::UdpHdrLen;

  always_comb begin
    sum_d.ip_sum = SW'({udprhb_pkg::VerIhl, cfg_i.ip_tos})
                 + SW'(tot16)
                 + SW'(fin_i.ident)
                 + SW'(cfg_i.ip_frag_word)
                 + SW'({cfg_i.ip_ttl, udprhb_pkg::ProtoUdp})
                 + SW'(fin_i.addr_sum);
    // Pseudo header, UDP header (length counted twice) and payload
    sum_d.udp_sum = SW'(fin_i.addr_sum)
                  + SW'(udprhb_pkg::ProtoUdp)
                  + SW'({ulen16, 1'b0})
                  + SW'(fin_i.src_port)
                  + SW'(fin_i.dst_port)
                  + SW'(fin_i.payload_sum);
    sum_d.tot_len  = tot16[10:0];
    sum_d.udp_len  = ulen16[10:0];
    sum_d.ident    = fin_i.ident;
    sum_d.too_long = fin_i.too_long;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (fin_ready_o) begin
      sum_valid_q <= fin_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_ready_o && fin_valid_i) begin
      sum_q <= sum_d;
    end
  end

  assign sum_valid_o = sum_valid_q;
  assign sum_o       = sum_q;

endmodule

`default_nettype wire

// ----- rtl/udprhb_out.sv -----
// ============================================================================
// udprhb_out: checksum finish and result register
// Folds and complements both sums, maps a zero UDP checksum to 0xFFFF and
// holds the result until the receiver takes it.
// ============================================================================
`default_nettype none

module udprhb_out (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 sum_valid_i,
  input  udprhb_pkg::sum_t    sum_i,
  output logic                sum_ready_o,
  output logic                out_valid_o,
  output udprhb_pkg::out_item_t out_data_o,
  input  wire                 out_ready_i
);

  logic                  out_valid_q;
  udprhb_pkg::out_item_t out_q, out_d;
  logic [15:0]           udp_cs;

  assign sum_ready_o = !out_valid_q || out_ready_i;

  assign udp_cs = ~udprhb_pkg::fold20(sum_i.udp_sum);

  always_comb begin
    out_d.ip_total_length = sum_i.tot_len;
    out_d.ip_ident        = sum_i.ident;
    out_d.ip_header_sum   = ~udprhb_pkg::fold20(sum_i.ip_sum);
    out_d.udp_length      = sum_i.udp_len;
    // Zero means "no checksum" in UDP, so send all ones instead
    out_d.udp_sum         = (udp_cs == 16'h0000) ? 16'hffff : udp_cs;
    out_d.too_long        = sum_i.too_long;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (sum_ready_o) begin
      out_valid_q <= sum_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_ready_o && sum_valid_i) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- rtl/udp_ipv4_reply_header_builder.sv -----
// ============================================================================
// udp_ipv4_reply_header_builder: IPv4/UDP reply header field generator
// Sums a UDP payload byte by byte and produces the lengths, IP ident and
// both checksums of the reply header on the last byte of each packet.
// ============================================================================
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one payload byte
//   per transfer; the transfer flagged last closes the packet and also
//   supplies addresses and ports. A transfer with has_byte low and last high
//   closes the packet without adding a byte; one with both low is dropped.
//   Output channel (out_valid_o/out_ready_i/out_data_o) carries one header
//   result per packet.
//   Throughput: one transfer per clock while in_ready_o is high, set by the
//   combinational ones' complement add in the accumulator stage.
//   After the last transfer is taken, the result passes the input register,
//   accumulator record, sum stage and result register before it is valid.
//   Reset clears all packet state, sets the IP ident counter to 0x12a and
//   the registers to TOS 0, TTL 64, flags/fragment 0x4000.
//   When the receiver stalls, the result and up to two more packet records
//   wait in the pipeline; payload bytes still flow until a last transfer
//   finds no free slot, then in_ready_o drops.
//   Configuration writes (cfg_we_i) take effect at once and must be made
//   while no packet is in flight. Bytes past MAX_PAYLOAD set too_long.
// ============================================================================
`default_nettype none

module udp_ipv4_reply_header_builder #(
  parameter int unsigned MAX_PAYLOAD = 1472
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_ready_o,
  input  udprhb_pkg::in_item_t                in_data_i,
  output logic                                out_valid_o,
  input  wire                                 out_ready_i,
  output udprhb_pkg::out_item_t               out_data_o,
  input  wire                                 cfg_we_i,
  input  wire  [udprhb_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire  [udprhb_pkg::CfgW-1:0]         cfg_wdata_i
);

  udprhb_pkg::cfg_t     cfg_q;
  logic                 in_valid_q;
  udprhb_pkg::in_item_t in_q;
  logic                 acc_ready;
  logic                 fin_valid;
  udprhb_pkg::fin_t     fin;
  logic                 fin_ready;
  logic                 sum_valid;
  udprhb_pkg::sum_t     sum;
  logic                 sum_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ip_tos       <= udprhb_pkg::TosReset;
      cfg_q.ip_ttl       <= udprhb_pkg::TtlReset;
      cfg_q.ip_frag_word <= udprhb_pkg::FragReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        udprhb_pkg::REG_IP_TOS:  cfg_q.ip_tos       <= cfg_wdata_i[7:0];
        udprhb_pkg::REG_IP_TTL:  cfg_q.ip_ttl       <= cfg_wdata_i[7:0];
        udprhb_pkg::REG_IP_FRAG: cfg_q.ip_frag_word <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // Input register
  assign in_ready_o = !in_valid_q || acc_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  udprhb_accum #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_q),
    .item_i       (in_q),
    .item_ready_o (acc_ready),
    .fin_valid_o  (fin_valid),
    .fin_o        (fin),
    .fin_ready_i  (fin_ready)
  );

  udprhb_sum u_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .fin_valid_i (fin_valid),
    .fin_i       (fin),
    .fin_ready_o (fin_ready),
    .sum_valid_o (sum_valid),
    .sum_o       (sum),
    .sum_ready_i (sum_ready)
  );

  udprhb_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sum_valid_i (sum_valid),
    .sum_i       (sum),
    .sum_ready_o (sum_ready),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_ready_i (out_ready_i)
  );

endmodule

`default_nettype wire
